// File: rtl/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared request and status codes and field types for the reversible deque.
// ----------------------------------------------------------------------------
package rdd_pkg;

  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;

  typedef logic [REQ_W-1:0]    req_type_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_type_t REQ_LOAD    = 2'd0;
  localparam req_type_t REQ_REVERSE = 2'd1;
  localparam req_type_t REQ_DELETE  = 2'd2;
  localparam req_type_t REQ_FINISH  = 2'd3;

  localparam status_t ST_ELEMENT  = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_ERROR    = 2'd2;
  localparam status_t ST_OVERFLOW = 2'd3;

endpackage

// File: rtl/rdd_req_if.sv
// ----------------------------------------------------------------------------
// rdd_req_if
// Request channel: valid/ready handshake with request type and load value.
// ----------------------------------------------------------------------------
interface rdd_req_if;

  logic               valid;
  logic               ready;
  rdd_pkg::req_type_t req_type;
  rdd_pkg::value_t    load_value;

  modport source (output valid, output req_type, output load_value, input ready);
  modport sink   (input valid, input req_type, input load_value, output ready);

endinterface

// File: rtl/rdd_rsp_if.sv
// ----------------------------------------------------------------------------
// rdd_rsp_if
// Result channel: valid/ready handshake with value, status and last marker.
// ----------------------------------------------------------------------------
interface rdd_rsp_if;

  logic             valid;
  logic             ready;
  rdd_pkg::value_t  out_value;
  rdd_pkg::status_t out_status;
  logic             out_last;

  modport source (output valid, output out_value, output out_status, output out_last,
                  input ready);
  modport sink   (input valid, input out_value, input out_status, input out_last,
                  output ready);

endinterface

// File: rtl/reversible_deque_drain.sv
// ----------------------------------------------------------------------------
// reversible_deque_drain
// Ring-buffer deque with lazy reverse, delete-front and a draining finish.
//
//   channel  role    handshake    payload
//   req      sink    valid/ready  req_type, load_value
//   rsp      source  valid/ready  out_value, out_status, out_last
//
// Load, reverse and delete may follow back to back.
// A finish is accepted first, then the drain gives one result per cycle from the
// store read port: one per element, or a single status result.
// req.ready is low while a drain runs; the last result may still wait while
// new requests transfer. rsp stalls hold the drain in place.
// Reset clears the head pointer, count and flags; the store itself is not cleared.
// ----------------------------------------------------------------------------
module reversible_deque_drain #(
  parameter int STORE_DEPTH = 64,
  parameter int VALUE_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  rdd_req_if.sink   req,
  rdd_rsp_if.source rsp
);

  localparam int STORE_BITS = (VALUE_BITS < rdd_pkg::VALUE_W) ? VALUE_BITS : rdd_pkg::VALUE_W;
  localparam int AW         = $clog2(STORE_DEPTH);

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [STORE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [STORE_BITS-1:0] rd_data;

  rdd_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .STORE_BITS  (STORE_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rdd_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .STORE_BITS  (STORE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/rdd_store.sv
// ----------------------------------------------------------------------------
// rdd_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdd_store #(
  parameter int STORE_DEPTH = 64,
  parameter int STORE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic [STORE_BITS-1:0]          wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic [STORE_BITS-1:0]          rd_data
);

  logic [STORE_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rdd_ctrl.sv
// ----------------------------------------------------------------------------
// rdd_ctrl
// Pointer, count and flag control; drain sequencer over the store read port.
// ----------------------------------------------------------------------------
module rdd_ctrl #(
  parameter int STORE_DEPTH = 64,
  parameter int STORE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  rdd_req_if.sink                        req,
  rdd_rsp_if.source                      rsp,
  output logic                           wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  output logic [STORE_BITS-1:0]          wr_data,
  output logic                           rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  input  logic [STORE_BITS-1:0]          rd_data
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int VW   = rdd_pkg::VALUE_W;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic             state;
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic             rev;
  logic             err;
  logic             ovf;
  logic [CW-1:0]    drain_cnt;
  logic [AW-1:0]    drain_ptr;
  logic             drain_rev;
  rdd_pkg::status_t drain_code;
  logic             ovalid;
  rdd_pkg::status_t ostatus;
  logic             olast;

  logic             in_fire;
  logic             out_free;
  logic             full;
  logic [SUMW-1:0]  sum_tail;

  function automatic logic [AW-1:0] wrap(input logic [SUMW-1:0] s);
    logic [SUMW-1:0] d;
    d = s - SUMW'(STORE_DEPTH);
    return (s >= SUMW'(STORE_DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(STORE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(STORE_DEPTH - 1) : p - AW'(1);
  endfunction

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign out_free  = !ovalid || rsp.ready;
  assign full      = (count == CW'(STORE_DEPTH));
  assign sum_tail  = SUMW'(head) + SUMW'(count);

  assign wr_en   = in_fire && (req.req_type == rdd_pkg::REQ_LOAD) && !full;
  assign wr_addr = wrap(sum_tail);
  assign wr_data = req.load_value[STORE_BITS-1:0];
  assign rd_en   = (state == S_DRAIN) && out_free && (drain_code == rdd_pkg::ST_ELEMENT);
  assign rd_addr = drain_ptr;

  assign rsp.valid      = ovalid;
  assign rsp.out_status = ostatus;
  assign rsp.out_last   = olast;
  assign rsp.out_value  = (ostatus == rdd_pkg::ST_ELEMENT) ? VW'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rev       <= 1'b0;
      err       <= 1'b0;
      ovf       <= 1'b0;
      drain_cnt <= '0;
      ovalid    <= 1'b0;
    end else begin
      if (in_fire) begin
        unique case (req.req_type)
          rdd_pkg::REQ_LOAD: begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
          end
          rdd_pkg::REQ_REVERSE: begin
            rev <= !rev;
          end
          rdd_pkg::REQ_DELETE: begin
            if (!err) begin
              if (count == '0) begin
                err <= 1'b1;
              end else begin
                if (!rev) begin
                  head <= ptr_inc(head);
                end
                count <= count - CW'(1);
              end
            end
          end
          rdd_pkg::REQ_FINISH: begin
            drain_cnt <= count;
            drain_ptr <= rev ? wrap(sum_tail - SUMW'(1)) : head;
            drain_rev <= rev;
            if (ovf) begin
              drain_code <= rdd_pkg::ST_OVERFLOW;
            end else if (err) begin
              drain_code <= rdd_pkg::ST_ERROR;
            end else if (count == '0) begin
              drain_code <= rdd_pkg::ST_EMPTY;
            end else begin
              drain_code <= rdd_pkg::ST_ELEMENT;
            end
            head  <= '0;
            count <= '0;
            rev   <= 1'b0;
            err   <= 1'b0;
            ovf   <= 1'b0;
            state <= S_DRAIN;
          end
          default: begin
          end
        endcase
      end

      if ((state == S_DRAIN) && out_free) begin
        ovalid  <= 1'b1;
        ostatus <= drain_code;
        if (drain_code != rdd_pkg::ST_ELEMENT) begin
          olast <= 1'b1;
          state <= S_IDLE;
        end else begin
          olast     <= (drain_cnt == CW'(1));
          drain_cnt <= drain_cnt - CW'(1);
          drain_ptr <= drain_rev ? ptr_dec(drain_ptr) : ptr_inc(drain_ptr);
          if (drain_cnt == CW'(1)) begin
            state <= S_IDLE;
          end
        end
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("element count beyond store depth");

  a_read_has_element: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (drain_cnt != '0))
    else $error("store read with no element left to drain");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (req.req_type == rdd_pkg::REQ_FINISH)) |=>
      (count == '0) && !err && !ovf && !rev && (state == S_DRAIN))
    else $error("finish did not clear the queue");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (ovalid && (ostatus != rdd_pkg::ST_ELEMENT)) |-> olast)
    else $error("status result without last marker");

  a_drain_ends_last: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $past(state == S_DRAIN) && (state == S_IDLE)) |-> (ovalid && olast))
    else $error("drain ended without a last result");

endmodule
